// File: design/tccw_pkg.sv
// Shared types, constants and address helper for the text console cell writer.
`timescale 1ns / 1ps

package tccw_pkg;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam int LAST_ROW     = ROWS - 1;
    localparam int SCROLL_CELLS = COLUMNS * (ROWS - 1);

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 11;
    localparam int CELL_W = 16;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_PAD_W    = IN_TDATA_W - 8 - 8 - ADDR_W;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 8 - 8 - 8 - COL_W - ROW_W;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;

    typedef enum logic [1:0] {
        CMD_PRINT     = 2'd0,
        CMD_NEWLINE   = 2'd1,
        CMD_BACKSPACE = 2'd2,
        CMD_READ      = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         char_code;
        logic [7:0]         attr_color;
        logic [ADDR_W-1:0]  cell_index;
    } cmd_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] row);
        return ADDR_W'(col) + ADDR_W'(row) * ADDR_W'(COLUMNS);
    endfunction

endpackage

// File: design/tccw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/tccw_front.sv
// Front end: accepts input items, classifies them and queues the commands.
`timescale 1ns / 1ps

module tccw_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [tccw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tuser,
    input  logic                             clearing,
    output logic                             cmd_valid,
    output tccw_pkg::cmd_t                   cmd,
    input  logic                             cmd_pop
);

    tccw_pkg::cmd_t fifo_reg [2];
    tccw_pkg::cmd_t new_cmd;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic           push;
    logic           pop;
    logic [7:0]     in_char;

    assign in_char = s_axis_tdata[7:0];

    always_comb
    begin
        new_cmd.char_code  = in_char;
        new_cmd.attr_color = s_axis_tdata[15:8];
        new_cmd.cell_index = s_axis_tdata[16 +: tccw_pkg::ADDR_W];
        priority if (s_axis_tuser)
        begin
            new_cmd.kind = tccw_pkg::CMD_READ;
        end
        else if (in_char == tccw_pkg::CH_NEWLINE)
        begin
            new_cmd.kind = tccw_pkg::CMD_NEWLINE;
        end
        else if (in_char == tccw_pkg::CH_BACKSPACE)
        begin
            new_cmd.kind = tccw_pkg::CMD_BACKSPACE;
        end
        else
        begin
            new_cmd.kind = tccw_pkg::CMD_PRINT;
        end
    end

    assign s_axis_tready = (count_reg != 2'd2) && !clearing;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign cmd_valid     = (count_reg != 2'd0);
    assign pop           = cmd_pop && cmd_valid;
    assign cmd           = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// File: design/tccw_back.sv
// Back end: executes queued commands on the cell store and registers the results.
`timescale 1ns / 1ps

module tccw_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    input  tccw_pkg::cmd_t                   cmd,
    output logic                             cmd_pop,
    output logic                             clearing,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [tccw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tuser
);

    typedef enum logic [6:0] {
        ST_CLEAR      = 7'b0000001,
        ST_IDLE       = 7'b0000010,
        ST_RD_WAIT    = 7'b0000100,
        ST_BS_WR      = 7'b0001000,
        ST_SCROLL     = 7'b0010000,
        ST_SCROLL_CLR = 7'b0100000,
        ST_PUT_WR     = 7'b1000000
    } state_t;

    localparam logic [tccw_pkg::ADDR_W-1:0] LAST_CELL =
        tccw_pkg::ADDR_W'(tccw_pkg::CELLS - 1);
    localparam logic [tccw_pkg::ADDR_W-1:0] SCROLL_END =
        tccw_pkg::ADDR_W'(tccw_pkg::SCROLL_CELLS);
    localparam logic [tccw_pkg::ADDR_W-1:0] ROW_STEP =
        tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS);
    localparam logic [tccw_pkg::COL_W-1:0] COL_LIMIT =
        tccw_pkg::COL_W'(tccw_pkg::COLUMNS);
    localparam logic [tccw_pkg::ROW_W-1:0] ROW_LAST =
        tccw_pkg::ROW_W'(tccw_pkg::LAST_ROW);

    state_t                        state_reg;
    state_t                        state_next;
    logic [tccw_pkg::ADDR_W-1:0]   cnt_reg;
    logic [tccw_pkg::ADDR_W-1:0]   cnt_next;
    logic [tccw_pkg::COL_W-1:0]    col_reg;
    logic [tccw_pkg::COL_W-1:0]    col_next;
    logic [tccw_pkg::ROW_W-1:0]    row_reg;
    logic [tccw_pkg::ROW_W-1:0]    row_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    logic                          pend_put_reg;
    logic                          pend_put_next;
    logic [7:0]                    pend_char_reg;
    logic [7:0]                    pend_char_next;
    logic [7:0]                    pend_color_reg;
    logic [7:0]                    pend_color_next;
    logic [tccw_pkg::ADDR_W-1:0]   hold_addr_reg;
    logic [tccw_pkg::ADDR_W-1:0]   hold_addr_next;
    logic                          in_range_reg;
    logic                          in_range_next;

    logic                          out_serial_reg;
    logic [7:0]                    out_byte_reg;
    logic [7:0]                    out_char_reg;
    logic [7:0]                    out_color_reg;
    logic [tccw_pkg::COL_W-1:0]    out_col_reg;
    logic [tccw_pkg::ROW_W-1:0]    out_row_reg;

    logic                          load_out;
    logic                          out_serial;
    logic [7:0]                    out_byte;
    logic [7:0]                    out_char;
    logic [7:0]                    out_color;

    logic                          ram_we;
    logic [tccw_pkg::ADDR_W-1:0]   ram_waddr;
    logic [tccw_pkg::CELL_W-1:0]   ram_wdata;
    logic                          ram_re;
    logic [tccw_pkg::ADDR_W-1:0]   ram_raddr;
    logic [tccw_pkg::CELL_W-1:0]   ram_rdata;

    logic                          out_free;
    logic                          start;
    logic [tccw_pkg::COL_W-1:0]    c_tmp;
    logic [tccw_pkg::ROW_W-1:0]    r_tmp;

    tccw_ram #(
        .WIDTH (tccw_pkg::CELL_W),
        .DEPTH (tccw_pkg::CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || m_axis_tready;
    assign start    = cmd_valid && out_free;
    assign cmd_pop  = (state_reg == ST_IDLE) && start;
    assign clearing = (state_reg == ST_CLEAR);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        pend_put_next   = pend_put_reg;
        pend_char_next  = pend_char_reg;
        pend_color_next = pend_color_reg;
        hold_addr_next  = hold_addr_reg;
        in_range_next   = in_range_reg;
        load_out        = 1'b0;
        out_serial      = 1'b1;
        out_byte        = pend_char_reg;
        out_char        = 8'd0;
        out_color       = 8'd0;
        ram_we          = 1'b0;
        ram_waddr       = cnt_reg;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = cnt_reg;
        c_tmp           = col_reg;
        r_tmp           = row_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                out_byte = cmd.char_code;
                if (start)
                begin
                    pend_char_next  = cmd.char_code;
                    pend_color_next = cmd.attr_color;
                    unique case (cmd.kind)
                        tccw_pkg::CMD_READ:
                        begin
                            ram_re        = 1'b1;
                            ram_raddr     = cmd.cell_index;
                            in_range_next = (cmd.cell_index <= LAST_CELL);
                            state_next    = ST_RD_WAIT;
                        end

                        tccw_pkg::CMD_NEWLINE:
                        begin
                            col_next = '0;
                            if (row_reg >= ROW_LAST)
                            begin
                                row_next      = ROW_LAST;
                                pend_put_next = 1'b0;
                                cnt_next      = '0;
                                state_next    = ST_SCROLL;
                            end
                            else
                            begin
                                row_next = row_reg + 1'b1;
                                load_out = 1'b1;
                            end
                        end

                        tccw_pkg::CMD_BACKSPACE:
                        begin
                            if (col_reg != '0)
                            begin
                                c_tmp = col_reg - 1'b1;
                            end
                            if (c_tmp >= COL_LIMIT)
                            begin
                                c_tmp = COL_LIMIT - 1'b1;
                            end
                            col_next       = c_tmp;
                            ram_re         = 1'b1;
                            ram_raddr      = tccw_pkg::cell_addr(c_tmp, row_reg);
                            hold_addr_next = ram_raddr;
                            state_next     = ST_BS_WR;
                        end

                        tccw_pkg::CMD_PRINT:
                        begin
                            if (col_reg >= COL_LIMIT)
                            begin
                                c_tmp = '0;
                                if (row_reg < ROW_LAST)
                                begin
                                    r_tmp = row_reg + 1'b1;
                                end
                                else
                                begin
                                    r_tmp = ROW_LAST;
                                end
                            end
                            if (r_tmp >= ROW_LAST)
                            begin
                                col_next      = c_tmp;
                                row_next      = ROW_LAST - 1'b1;
                                pend_put_next = 1'b1;
                                cnt_next      = '0;
                                state_next    = ST_SCROLL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = tccw_pkg::cell_addr(c_tmp, r_tmp);
                                ram_wdata = {cmd.attr_color, cmd.char_code};
                                col_next  = c_tmp + 1'b1;
                                row_next  = r_tmp;
                                load_out  = 1'b1;
                            end
                        end

                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_RD_WAIT:
            begin
                load_out   = 1'b1;
                out_serial = 1'b0;
                out_byte   = 8'd0;
                if (in_range_reg)
                begin
                    out_char  = ram_rdata[7:0];
                    out_color = ram_rdata[15:8];
                end
                state_next = ST_IDLE;
            end

            ST_BS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = hold_addr_reg;
                ram_wdata  = {ram_rdata[15:8], 8'd0};
                load_out   = 1'b1;
                state_next = ST_IDLE;
            end

            ST_SCROLL:
            begin
                if (cnt_reg != SCROLL_END)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = cnt_reg + ROW_STEP;
                end
                if (cnt_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (cnt_reg == SCROLL_END)
                begin
                    cnt_next   = '0;
                    state_next = ST_SCROLL_CLR;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_SCROLL_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = SCROLL_END + cnt_reg;
                if (cnt_reg == ROW_STEP - 1'b1)
                begin
                    cnt_next = '0;
                    if (pend_put_reg)
                    begin
                        state_next = ST_PUT_WR;
                    end
                    else
                    begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_PUT_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = tccw_pkg::cell_addr(col_reg, row_reg);
                ram_wdata  = {pend_color_reg, pend_char_reg};
                col_next   = col_reg + 1'b1;
                load_out   = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            pend_put_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            pend_put_reg  <= pend_put_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_char_reg  <= pend_char_next;
        pend_color_reg <= pend_color_next;
        hold_addr_reg  <= hold_addr_next;
        in_range_reg   <= in_range_next;
        if (load_out)
        begin
            out_serial_reg <= out_serial;
            out_byte_reg   <= out_byte;
            out_char_reg   <= out_char;
            out_color_reg  <= out_color;
            out_col_reg    <= col_next;
            out_row_reg    <= row_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_serial_reg;
    assign m_axis_tdata  = {{tccw_pkg::OUT_PAD_W{1'b0}}, out_row_reg, out_col_reg,
                            out_color_reg, out_char_reg, out_byte_reg};

endmodule

// File: design/text_console_cell_writer.sv
// Top level of the text console cell writer: front end, command queue and back end.
`timescale 1ns / 1ps

// The block keeps an 80 by 25 store of character and colour cells and a cursor.
// Items arrive on the s_axis channel: tuser set asks for one cell to be read,
// tuser clear puts a character at the cursor (newline and backspace act on the
// cursor). Every item gives exactly one result item on the m_axis channel,
// carrying the echoed byte, the cell read and the cursor after the item.
// A front end classifies items into a two-entry queue; the back end executes
// them against a single-port-write, registered-read cell memory.
// An ordinary put is written and answered from the idle state, while a read or
// a backspace first reads the memory and answers from ST_RD_WAIT or ST_BS_WR.
// A put or newline that scrolls walks the whole memory through its one write
// port, copying every row but the top one up a row, then clearing the bottom row.
// After reset the memory is cleared by a pass over every cell, during which
// s_axis_tready stays low. When the receiver holds m_axis_tready low, the
// result waits in the output register and the queue fills, after which
// s_axis_tready falls until the result is taken.
module text_console_cell_writer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // char_code[7:0], attr_color[15:8], cell_index[26:16], zeros above
    input  logic [tccw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // serial_byte[7:0], cell_char[15:8], cell_color[23:16], cursor_col[30:24],
    // cursor_row[35:31], zeros above
    output logic [tccw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // serial_valid
    output logic                             m_axis_tuser
);

    logic           cmd_valid;
    tccw_pkg::cmd_t cmd;
    logic           cmd_pop;
    logic           clearing;

    tccw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .clearing      (clearing),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    tccw_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .clearing      (clearing),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// File: tb/text_console_cell_writer_test.sv
// Self-checking testbench for the text console cell writer over its stream ports.
`timescale 1ns / 1ps

module text_console_cell_writer_test;

    typedef struct packed {
        logic                       serial_valid;
        logic [7:0]                 serial_byte;
        logic [7:0]                 cell_char;
        logic [7:0]                 cell_color;
        logic [tccw_pkg::COL_W-1:0] cursor_col;
        logic [tccw_pkg::ROW_W-1:0] cursor_row;
    } console_result_t;

    typedef struct packed {
        tccw_pkg::cmd_kind_t         kind;
        logic [7:0]                  char_code;
        logic [7:0]                  attr_color;
        logic [tccw_pkg::ADDR_W-1:0] cell_index;
        int                          reps;
        logic                        known;
        console_result_t             want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 22;
    localparam int RANDOM_ITEMS  = 1045;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [tccw_pkg::IN_TDATA_W-1:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [tccw_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    logic [tccw_pkg::CELL_W-1:0] screen_model [tccw_pkg::CELLS];
    int cursor_col_model;
    int cursor_row_model;

    console_result_t expected_results [$];
    stim_row_t directed_rows [DIRECTED_ROWS];

    int mismatch_count;
    int items_sent;
    int tx_idle_pct;
    int rx_idle_pct;
    bit holdoff_done;

    text_console_cell_writer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #(64'd50_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void shift_screen_up();
        for (int i = 0; i < tccw_pkg::SCROLL_CELLS; i++)
        begin
            screen_model[i] = screen_model[i + tccw_pkg::COLUMNS];
        end
        for (int i = tccw_pkg::SCROLL_CELLS; i < tccw_pkg::CELLS; i++)
        begin
            screen_model[i] = '0;
        end
    endfunction

    function automatic int cursor_cell();
        int pos;
        pos = cursor_col_model + tccw_pkg::COLUMNS * cursor_row_model;
        return (pos < tccw_pkg::CELLS) ? pos : 0;
    endfunction

    function automatic console_result_t console_apply(logic is_read, logic [7:0] ch,
                                                      logic [7:0] color,
                                                      logic [tccw_pkg::ADDR_W-1:0] idx);
        console_result_t r;
        int pos;
        r = '0;
        if (!is_read)
        begin
            r.serial_valid = 1'b1;
            r.serial_byte = ch;
            if (ch == tccw_pkg::CH_NEWLINE)
            begin
                cursor_col_model = 0;
                if (cursor_row_model >= tccw_pkg::LAST_ROW)
                begin
                    cursor_row_model = tccw_pkg::LAST_ROW;
                    shift_screen_up();
                end
                else
                begin
                    cursor_row_model++;
                end
            end
            else if (ch == tccw_pkg::CH_BACKSPACE)
            begin
                if (cursor_col_model > 0)
                begin
                    cursor_col_model--;
                end
                if (cursor_col_model >= tccw_pkg::COLUMNS)
                begin
                    cursor_col_model = tccw_pkg::COLUMNS - 1;
                end
                pos = cursor_cell();
                screen_model[pos][7:0] = 8'h00;
            end
            else
            begin
                if (cursor_col_model >= tccw_pkg::COLUMNS)
                begin
                    cursor_col_model = 0;
                    if (cursor_row_model < tccw_pkg::LAST_ROW)
                    begin
                        cursor_row_model++;
                    end
                    else
                    begin
                        cursor_row_model = tccw_pkg::LAST_ROW;
                    end
                end
                if (cursor_row_model >= tccw_pkg::LAST_ROW)
                begin
                    shift_screen_up();
                    cursor_row_model = tccw_pkg::LAST_ROW - 1;
                end
                pos = cursor_cell();
                screen_model[pos] = {color, ch};
                cursor_col_model++;
            end
        end
        else if (idx < tccw_pkg::CELLS)
        begin
            r.cell_char = screen_model[idx][7:0];
            r.cell_color = screen_model[idx][15:8];
        end
        r.cursor_col = tccw_pkg::COL_W'(cursor_col_model);
        r.cursor_row = tccw_pkg::ROW_W'(cursor_row_model);
        return r;
    endfunction

    function automatic stim_row_t stim_row(tccw_pkg::cmd_kind_t kind, logic [7:0] ch,
                                           logic [7:0] color,
                                           logic [tccw_pkg::ADDR_W-1:0] idx, int reps,
                                           logic known, console_result_t want);
        stim_row_t s;
        s.kind = kind;
        s.char_code = ch;
        s.attr_color = color;
        s.cell_index = idx;
        s.reps = reps;
        s.known = known;
        s.want = want;
        return s;
    endfunction

    task automatic send_item(tccw_pkg::cmd_kind_t kind, logic [7:0] ch, logic [7:0] color,
                             logic [tccw_pkg::ADDR_W-1:0] idx, logic known,
                             console_result_t want);
        logic [7:0] code;
        logic is_read;
        console_result_t predicted;
        is_read = (kind == tccw_pkg::CMD_READ);
        code = (kind == tccw_pkg::CMD_NEWLINE) ? tccw_pkg::CH_NEWLINE :
               (kind == tccw_pkg::CMD_BACKSPACE) ? tccw_pkg::CH_BACKSPACE : ch;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= is_read;
        s_axis_tdata <= {{tccw_pkg::IN_PAD_W{1'b0}}, idx, color, code};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        predicted = console_apply(is_read, code, color, idx);
        expected_results.push_back(known ? want : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    task automatic check_result();
        console_result_t want;
        if (expected_results.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        end
        else
        begin
            want = expected_results.pop_front();
            check_field("serial_valid", 32'(want.serial_valid), 32'(m_axis_tuser));
            check_field("serial_byte", 32'(want.serial_byte), 32'(m_axis_tdata[7:0]));
            check_field("cell_char", 32'(want.cell_char), 32'(m_axis_tdata[15:8]));
            check_field("cell_color", 32'(want.cell_color), 32'(m_axis_tdata[23:16]));
            check_field("cursor_col", 32'(want.cursor_col), 32'(m_axis_tdata[30:24]));
            check_field("cursor_row", 32'(want.cursor_row), 32'(m_axis_tdata[35:31]));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            check_result();
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!holdoff_done && items_sent >= 600)
            begin
                holdoff_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
                @(negedge clk);
            end
        end
    end

    initial
    begin
        tccw_pkg::cmd_kind_t kind;
        logic [7:0] ch;
        logic [7:0] color;
        logic [tccw_pkg::ADDR_W-1:0] idx;
        int burst;
        int p;
        int read_pct;
        int nl_pct;
        int bs_pct;
        int base_row;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        mismatch_count = 0;
        items_sent = 0;
        holdoff_done = 1'b0;
        tx_idle_pct = 37;
        rx_idle_pct = 60;
        cursor_col_model = 0;
        cursor_row_model = 0;
        for (int i = 0; i < tccw_pkg::CELLS; i++)
        begin
            screen_model[i] = '0;
        end

        directed_rows[0] = stim_row(tccw_pkg::CMD_READ, 8'h00, 8'h00, 11'd0, 1, 1'b1, '0);
        directed_rows[1] = stim_row(tccw_pkg::CMD_READ, 8'hff, 8'hff, 11'd1999, 1, 1'b1, '0);
        directed_rows[2] = stim_row(tccw_pkg::CMD_READ, 8'h00, 8'h00, 11'd2047, 1, 1'b1, '0);
        directed_rows[3] = stim_row(tccw_pkg::CMD_PRINT, 8'h41, 8'hff, 11'd0, 1, 1'b1,
                                    {1'b1, 8'h41, 8'h00, 8'h00, 7'd1, 5'd0});
        directed_rows[4] = stim_row(tccw_pkg::CMD_PRINT, 8'hff, 8'h00, 11'd2047, 1, 1'b0, '0);
        directed_rows[5] = stim_row(tccw_pkg::CMD_PRINT, 8'h00, 8'h80, 11'd0, 1, 1'b0, '0);
        directed_rows[6] = stim_row(tccw_pkg::CMD_READ, 8'h00, 8'h00, 11'd0, 1, 1'b0, '0);
        directed_rows[7] = stim_row(tccw_pkg::CMD_BACKSPACE, 8'h00, 8'h55, 11'd0, 4, 1'b0, '0);
        directed_rows[8] = stim_row(tccw_pkg::CMD_READ, 8'h00, 8'h00, 11'd2, 1, 1'b0, '0);
        directed_rows[9] = stim_row(tccw_pkg::CMD_PRINT, 8'h78, 8'h1e, 11'd0, 80, 1'b0, '0);
        directed_rows[10] = stim_row(tccw_pkg::CMD_BACKSPACE, 8'h00, 8'h00, 11'd0, 1, 1'b0,
                                     '0);
        directed_rows[11] = stim_row(tccw_pkg::CMD_PRINT, 8'h79, 8'h2f, 11'd0, 1, 1'b0, '0);
        directed_rows[12] = stim_row(tccw_pkg::CMD_PRINT, 8'h7a, 8'h3c, 11'd0, 1, 1'b0, '0);
        directed_rows[13] = stim_row(tccw_pkg::CMD_NEWLINE, 8'h00, 8'h00, 11'd0, 23, 1'b0,
                                     '0);
        directed_rows[14] = stim_row(tccw_pkg::CMD_NEWLINE, 8'h00, 8'h00, 11'd0, 1, 1'b0, '0);
        directed_rows[15] = stim_row(tccw_pkg::CMD_PRINT, 8'h71, 8'h4e, 11'd0, 1, 1'b0, '0);
        directed_rows[16] = stim_row(tccw_pkg::CMD_NEWLINE, 8'h00, 8'h00, 11'd0, 1, 1'b0, '0);
        directed_rows[17] = stim_row(tccw_pkg::CMD_PRINT, 8'h72, 8'h07, 11'd0, 80, 1'b0, '0);
        directed_rows[18] = stim_row(tccw_pkg::CMD_PRINT, 8'h73, 8'hf0, 11'd0, 1, 1'b0, '0);
        directed_rows[19] = stim_row(tccw_pkg::CMD_READ, 8'h00, 8'h00, 11'd1840, 1, 1'b0, '0);
        directed_rows[20] = stim_row(tccw_pkg::CMD_READ, 8'h00, 8'h00, 11'd1920, 1, 1'b0, '0);
        directed_rows[21] = stim_row(tccw_pkg::CMD_READ, 8'h00, 8'h00, 11'd1839, 1, 1'b0, '0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            for (int k = 0; k < directed_rows[r].reps; k++)
            begin
                send_item(directed_rows[r].kind, directed_rows[r].char_code,
                          directed_rows[r].attr_color, directed_rows[r].cell_index,
                          directed_rows[r].known, directed_rows[r].want);
            end
        end

        read_pct = 30;
        nl_pct = 4;
        bs_pct = 8;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 348)
            begin
                tx_idle_pct = 60;
                rx_idle_pct = 37;
            end
            if (n == 697)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (n == 522)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
                while (expected_results.size() != 0)
                begin
                    @(negedge clk);
                end
            end
            if (n % 40 == 0)
            begin
                burst = $urandom_range(0, 99);
                if (burst < 55)
                begin
                    read_pct = 30;
                    nl_pct = 4;
                    bs_pct = 8;
                end
                else if (burst < 75)
                begin
                    read_pct = 8;
                    nl_pct = 1;
                    bs_pct = 0;
                end
                else if (burst < 85)
                begin
                    read_pct = 15;
                    nl_pct = 40;
                    bs_pct = 0;
                end
                else
                begin
                    read_pct = 40;
                    nl_pct = 0;
                    bs_pct = 30;
                end
            end
            p = $urandom_range(0, 99);
            if (p < read_pct)
            begin
                kind = tccw_pkg::CMD_READ;
            end
            else if (p < read_pct + nl_pct)
            begin
                kind = tccw_pkg::CMD_NEWLINE;
            end
            else if (p < read_pct + nl_pct + bs_pct)
            begin
                kind = tccw_pkg::CMD_BACKSPACE;
            end
            else
            begin
                kind = tccw_pkg::CMD_PRINT;
            end
            ch = 8'($urandom_range(0, 255));
            color = 8'($urandom_range(0, 255));
            p = $urandom_range(0, 9);
            if (p == 0)
            begin
                idx = tccw_pkg::ADDR_W'($urandom_range(tccw_pkg::CELLS, 2047));
            end
            else if (p < 5)
            begin
                base_row = (cursor_row_model > 0) ? cursor_row_model - 1 : 0;
                idx = tccw_pkg::ADDR_W'(base_row * tccw_pkg::COLUMNS +
                                        $urandom_range(0, 2 * tccw_pkg::COLUMNS - 1));
            end
            else
            begin
                idx = tccw_pkg::ADDR_W'($urandom_range(0, tccw_pkg::CELLS - 1));
            end
            send_item(kind, ch, color, idx, 1'b0, '0);
        end

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/tccw_pkg.sv
design/tccw_ram.sv
design/tccw_front.sv
design/tccw_back.sv
design/text_console_cell_writer.sv
tb/text_console_cell_writer_test.sv
